// File: hdl/cmsr_pkg.sv
package cmsr_pkg;

  typedef enum logic [2:0] {
    FN_HOST     = 3'd0,
    FN_ROW_WR   = 3'd1,
    FN_BATT     = 3'd2,
    FN_KEY_DOWN = 3'd3,
    FN_TOUCH    = 3'd4,
    FN_PEN_UP   = 3'd5,
    FN_RSVD6    = 3'd6,
    FN_RSVD7    = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SCAN
  } state_t;

  localparam logic [7:0] OP_BATT_MAIN   = 8'h70;
  localparam logic [7:0] OP_BATT_BACKUP = 8'h71;
  localparam logic [7:0] OP_SCAN        = 8'h13;
  localparam logic [7:0] OP_KEY_DOWN    = 8'h12;
  localparam logic [7:0] OP_TOUCH       = 8'h04;
  localparam logic [7:0] OP_PEN_UP      = 8'h05;
  localparam logic [7:0] BYTE_MASK      = 8'hFF;

  localparam int FUNC_W  = 3;
  localparam int IN_W    = 72;
  localparam int REPLY_W = 40;

endpackage

// File: hdl/companion_mcu_serial_responder.sv
// a taken item moves to ST_EMIT, which registers the first reply byte onto out_tdata
// one item at a time; in_tready is low until the last reply byte is registered
// a key scan reply is MATRIX_ROWS + 1 bytes, read one row per cycle from the row memory
// while the output is not stalled; items with no reply leave the input ready
// reset (rst_n low, synchronous): control idle, battery level and all rows read as zero
module companion_mcu_serial_responder
  import cmsr_pkg::*;
#(
  parameter int MATRIX_ROWS = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // rx_byte, matrix_row, matrix_value, battery_raw, touch_x, touch_y
  input  logic [IN_W-1:0]   in_tdata,
  // func
  input  logic [FUNC_W-1:0] in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // tx_byte
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);

  localparam int AW = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  cmsr_seq #(
    .MATRIX_ROWS(MATRIX_ROWS),
    .AW(AW)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_func        (in_tuser),
    .in_rx_byte     (in_tdata[7:0]),
    .in_matrix_row  (in_tdata[11:8]),
    .in_matrix_value(in_tdata[19:12]),
    .in_battery_raw (in_tdata[35:20]),
    .in_touch_x     (in_tdata[51:36]),
    .in_touch_y     (in_tdata[67:52]),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tx_byte    (out_tdata),
    .out_last       (out_tlast),
    .mem_wr_en      (wr_en),
    .mem_wr_addr    (wr_addr),
    .mem_wr_data    (wr_data),
    .mem_rd_addr    (rd_addr),
    .mem_rd_data    (rd_data)
  );

  cmsr_kmem #(
    .MATRIX_ROWS(MATRIX_ROWS),
    .AW(AW)
  ) u_kmem (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

// File: hdl/cmsr_kmem.sv
module cmsr_kmem #(
  parameter int MATRIX_ROWS = 13,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]             mem [MATRIX_ROWS];
  logic [MATRIX_ROWS-1:0] vld_r;
  logic [7:0]             mem_q_r;
  logic                   vld_q_r;

  // row data, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  // rows never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      vld_q_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : 8'h00;

endmodule

// File: hdl/cmsr_seq.sv
module cmsr_seq
  import cmsr_pkg::*;
#(
  parameter int MATRIX_ROWS = 13,
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [7:0]        in_rx_byte,
  input  logic [3:0]        in_matrix_row,
  input  logic [7:0]        in_matrix_value,
  input  logic [15:0]       in_battery_raw,
  input  logic [15:0]       in_touch_x,
  input  logic [15:0]       in_touch_y,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tx_byte,
  output logic              out_last,
  output logic              mem_wr_en,
  output logic [AW-1:0]     mem_wr_addr,
  output logic [7:0]        mem_wr_data,
  output logic [AW-1:0]     mem_rd_addr,
  input  logic [7:0]        mem_rd_data
);

  localparam logic [AW-1:0] ROW_LAST = AW'(MATRIX_ROWS - 1);

  state_t               state_r, state_nxt;
  logic [REPLY_W-1:0]   buf_r, buf_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic                 scan_r, scan_nxt;
  logic [AW-1:0]        row_r, row_nxt;
  logic [15:0]          batt_r, batt_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 acc;
  logic                 ld;

  assign in_tready   = (state_r == ST_IDLE);
  assign acc         = in_tvalid && in_tready;
  assign ld          = !out_vld_r || out_tready;
  assign out_tvalid  = out_vld_r;
  assign out_tx_byte = out_byte_r;
  assign out_last    = out_last_r;
  assign mem_rd_addr = row_nxt;
  assign mem_wr_addr = AW'(in_matrix_row);
  assign mem_wr_data = in_matrix_value;

  always_comb begin
    state_nxt    = state_r;
    buf_nxt      = buf_r;
    cnt_nxt      = cnt_r;
    scan_nxt     = scan_r;
    row_nxt      = row_r;
    batt_nxt     = batt_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    mem_wr_en    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (func_t'(in_func))
            FN_HOST: begin
              if (in_rx_byte == OP_BATT_MAIN || in_rx_byte == OP_BATT_BACKUP) begin
                buf_nxt   = {OP_BATT_MAIN, batt_r, 16'h0000};
                cnt_nxt   = 3'd2;
                state_nxt = ST_EMIT;
              end else if (in_rx_byte == OP_SCAN) begin
                buf_nxt   = {OP_SCAN, 32'h0};
                cnt_nxt   = 3'd0;
                scan_nxt  = 1'b1;
                state_nxt = ST_EMIT;
              end
            end
            FN_ROW_WR: begin
              mem_wr_en = (6'(in_matrix_row) < 6'(MATRIX_ROWS));
            end
            FN_BATT: begin
              batt_nxt = in_battery_raw;
            end
            FN_KEY_DOWN: begin
              buf_nxt   = {OP_KEY_DOWN, 32'h0};
              cnt_nxt   = 3'd0;
              state_nxt = ST_EMIT;
            end
            FN_TOUCH: begin
              buf_nxt   = {OP_TOUCH, in_touch_x, in_touch_y};
              cnt_nxt   = 3'd4;
              state_nxt = ST_EMIT;
            end
            FN_PEN_UP: begin
              buf_nxt   = {OP_PEN_UP, 32'h0};
              cnt_nxt   = 3'd0;
              state_nxt = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (ld) begin
          out_vld_nxt  = 1'b1;
          out_byte_nxt = buf_r[REPLY_W-1 -: 8] & BYTE_MASK;
          out_last_nxt = (cnt_r == 3'd0) && !scan_r;
          buf_nxt      = {buf_r[REPLY_W-9:0], 8'h00};
          cnt_nxt      = cnt_r - 3'd1;
          if (cnt_r == 3'd0) begin
            state_nxt = scan_r ? ST_SCAN : ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (ld) begin
          out_vld_nxt  = 1'b1;
          out_byte_nxt = mem_rd_data;
          out_last_nxt = (row_r == ROW_LAST);
          if (row_r == ROW_LAST) begin
            row_nxt   = '0;
            scan_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            row_nxt = row_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      scan_r    <= 1'b0;
      row_r     <= '0;
      batt_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      scan_r    <= scan_nxt;
      row_r     <= row_nxt;
      batt_r    <= batt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r      <= buf_nxt;
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// File: hdl/cmsr_chk.sv
module cmsr_chk
  import cmsr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [FUNC_W-1:0] in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [7:0]        out_tdata,
  input logic              out_tlast
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // state-only items never produce a word
  a_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_tvalid &&
    (in_tuser == FN_ROW_WR || in_tuser == FN_BATT ||
     in_tuser == FN_RSVD6 || in_tuser == FN_RSVD7)
    |=> !out_tvalid)
    else $error("word from an item with no reply");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == FN_KEY_DOWN || in_tuser == FN_TOUCH || in_tuser == FN_PEN_UP)
    |=> !in_tready)
    else $error("input taken while a reply is pending");

  a_key_down: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_tvalid && in_tuser == FN_KEY_DOWN
    |=> ##1 out_tvalid && out_tdata == OP_KEY_DOWN && out_tlast)
    else $error("key down report wrong");

endmodule

bind companion_mcu_serial_responder cmsr_chk u_cmsr_chk (.*);

// File: tb/tb_companion_mcu_serial_responder.sv
`timescale 1ns / 1ps

module tb_companion_mcu_serial_responder;
  import cmsr_pkg::*;

  localparam int ROWS = 13;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [7:0]        rx_byte;
    logic [3:0]        row;
    logic [7:0]        row_value;
    logic [15:0]       batt_raw;
    logic [15:0]       touch_x;
    logic [15:0]       touch_y;
  } event_t;

  typedef struct {
    logic [7:0] tx_byte;
    logic       last;
  } reply_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic [FUNC_W-1:0] in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              out_tlast;

  event_t      pending_events[$];
  reply_byte_t reply_bytes[$];
  event_t      cur_event;
  logic [7:0]  key_rows[ROWS];
  logic [15:0] batt_level;
  int          n_errors = 0;
  int          cycles = 0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  companion_mcu_serial_responder #(
    .MATRIX_ROWS(ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    n_errors++;
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic event_t rand_event(input logic [FUNC_W-1:0] func);
    event_t e;
    e.func = func;
    e.rx_byte = 8'($urandom);
    e.row = 4'($urandom);
    e.row_value = 8'($urandom);
    e.batt_raw = 16'($urandom);
    e.touch_x = 16'($urandom);
    e.touch_y = 16'($urandom);
    return e;
  endfunction

  function automatic logic [IN_W-1:0] pack_event(input event_t e);
    return {4'b0, e.touch_y, e.touch_x, e.batt_raw, e.row_value, e.row, e.rx_byte};
  endfunction

  task automatic push_reply(input logic [7:0] b, input logic last);
    reply_byte_t r;
    r.tx_byte = b;
    r.last = last;
    reply_bytes.push_back(r);
  endtask

  // state update and expected reply for one taken event
  task automatic apply_event(input event_t e);
    case (e.func)
      FN_HOST: begin
        if (e.rx_byte == OP_BATT_MAIN || e.rx_byte == OP_BATT_BACKUP) begin
          push_reply(OP_BATT_MAIN, 1'b0);
          push_reply(batt_level[15:8], 1'b0);
          push_reply(batt_level[7:0], 1'b1);
        end else if (e.rx_byte == OP_SCAN) begin
          push_reply(OP_SCAN, 1'b0);
          for (int i = 0; i < ROWS; i++) push_reply(key_rows[i], i == ROWS - 1);
        end
      end
      FN_ROW_WR: begin
        if (e.row < ROWS) key_rows[e.row] = e.row_value;
      end
      FN_BATT: batt_level = e.batt_raw;
      FN_KEY_DOWN: push_reply(OP_KEY_DOWN, 1'b1);
      FN_TOUCH: begin
        push_reply(OP_TOUCH, 1'b0);
        push_reply(e.touch_x[15:8], 1'b0);
        push_reply(e.touch_x[7:0], 1'b0);
        push_reply(e.touch_y[15:8], 1'b0);
        push_reply(e.touch_y[7:0], 1'b1);
      end
      FN_PEN_UP: push_reply(OP_PEN_UP, 1'b1);
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        apply_event(cur_event);
        busy = 1'b0;
      end
      if (!busy) begin
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          cur_event = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= pack_event(cur_event);
          in_tuser <= cur_event.func;
          in_gap = pick_gap(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_byte_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (reply_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
        end else begin
          want = reply_bytes.pop_front();
          if (out_tdata !== want.tx_byte)
            report_mismatch($sformatf("tx_byte %02h, want %02h", out_tdata, want.tx_byte));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_tlast, want.last));
        end
      end
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_event(input event_t e);
    pending_events.push_back(e);
  endtask

  initial begin
    event_t e;
    int r;
    for (int i = 0; i < ROWS; i++) key_rows[i] = '0;
    batt_level = '0;

    // reset values read back
    e = rand_event(FN_HOST); e.rx_byte = OP_BATT_MAIN; add_event(e);
    e = rand_event(FN_HOST); e.rx_byte = OP_SCAN; add_event(e);
    // battery maximum and both request codes
    e = rand_event(FN_BATT); e.batt_raw = 16'hFFFF; add_event(e);
    e = rand_event(FN_HOST); e.rx_byte = OP_BATT_BACKUP; add_event(e);
    e = rand_event(FN_HOST); e.rx_byte = OP_BATT_MAIN; add_event(e);
    // row writes, first and last row, out of range rows
    e = rand_event(FN_ROW_WR); e.row = 4'd0; e.row_value = 8'hFF; add_event(e);
    e = rand_event(FN_ROW_WR); e.row = 4'(ROWS - 1); e.row_value = 8'h80; add_event(e);
    e = rand_event(FN_ROW_WR); e.row = 4'(ROWS); e.row_value = 8'h55; add_event(e);
    e = rand_event(FN_ROW_WR); e.row = 4'd15; e.row_value = 8'hAA; add_event(e);
    e = rand_event(FN_HOST); e.rx_byte = OP_SCAN; add_event(e);
    // host bytes with no reply
    e = rand_event(FN_HOST); e.rx_byte = 8'h00; add_event(e);
    e = rand_event(FN_HOST); e.rx_byte = 8'hFF; add_event(e);
    e = rand_event(FN_HOST); e.rx_byte = OP_KEY_DOWN; add_event(e);
    // reports
    e = rand_event(FN_KEY_DOWN); add_event(e);
    e = rand_event(FN_TOUCH); e.touch_x = 16'h0000; e.touch_y = 16'h0000; add_event(e);
    e = rand_event(FN_TOUCH); e.touch_x = 16'hFFFF; e.touch_y = 16'hFFFF; add_event(e);
    e = rand_event(FN_TOUCH); e.touch_x = 16'h8001; e.touch_y = 16'h7FFE; add_event(e);
    e = rand_event(FN_PEN_UP); add_event(e);
    // unused func codes, then the battery minimum read back
    e = rand_event(FN_RSVD6); add_event(e);
    e = rand_event(FN_RSVD7); add_event(e);
    e = rand_event(FN_BATT); e.batt_raw = 16'h0000; add_event(e);
    e = rand_event(FN_HOST); e.rx_byte = OP_BATT_BACKUP; add_event(e);

    for (int n = 0; n < 78; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        e = rand_event(FN_HOST);
        case ($urandom_range(0, 3))
          0: e.rx_byte = OP_BATT_MAIN;
          1: e.rx_byte = OP_BATT_BACKUP;
          2: e.rx_byte = OP_SCAN;
          default: ;
        endcase
      end else if (r < 50) begin
        e = rand_event(FN_ROW_WR);
        if ($urandom_range(0, 7) != 0) e.row = 4'($urandom_range(0, ROWS - 1));
        else e.row = 4'($urandom_range(ROWS, 15));
      end else if (r < 60) begin
        e = rand_event(FN_BATT);
      end else if (r < 70) begin
        e = rand_event(FN_KEY_DOWN);
      end else if (r < 85) begin
        e = rand_event(FN_TOUCH);
      end else if (r < 95) begin
        e = rand_event(FN_PEN_UP);
      end else begin
        e = rand_event($urandom_range(0, 1) ? FN_RSVD6 : FN_RSVD7);
      end
      add_event(e);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_events.size() > 0 || in_tvalid || reply_bytes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (reply_bytes.size() > 0)
      report_mismatch($sformatf("%0d reply bytes never arrived", reply_bytes.size()));
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
